[design/selectable_string_hash_assert.svh]
// Assertion macros shared by the checker of selectable_string_hash.
// Expects clk and rst_n in scope where used.
`ifndef SELECTABLE_STRING_HASH_ASSERT_SVH
`define SELECTABLE_STRING_HASH_ASSERT_SVH

// cons must hold in the same cycle as ante
`define SSH_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ssh assertion failed");

// cons must hold in the cycle after ante
`define SSH_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ssh assertion failed");

`endif

[design/ssh_pkg.sv]
// Package for selectable_string_hash: algorithm codes, start values, helpers.
// No dependencies.
package ssh_pkg;

    typedef enum logic [2:0] {
        ALG_DJB  = 3'd0,
        ALG_BKDR = 3'd1,
        ALG_RS   = 3'd2,
        ALG_AP   = 3'd3,
        ALG_JS   = 3'd4
    } algo_t;

    localparam logic [31:0] DJB_INIT  = 32'd5381;
    localparam logic [31:0] JS_INIT   = 32'd1315423911;
    localparam logic [31:0] BKDR_SEED = 32'd131;
    localparam logic [31:0] RS_M_INIT = 32'd63689;
    localparam logic [31:0] RS_M_STEP = 32'd378851;

    typedef struct packed {
        algo_t algo;
        logic  odd;
    } fold_ctl_t;

    // selector codes above 4 wrap modulo 5
    function automatic algo_t algo_of(input logic [2:0] sel);
        algo_t a;
        case (sel)
            3'd0, 3'd5: a = ALG_DJB;
            3'd1, 3'd6: a = ALG_BKDR;
            3'd2, 3'd7: a = ALG_RS;
            3'd3:       a = ALG_AP;
            default:    a = ALG_JS;
        endcase
        return a;
    endfunction

    function automatic logic [31:0] init_of(input algo_t a);
        logic [31:0] v;
        case (a)
            ALG_DJB: v = DJB_INIT;
            ALG_JS:  v = JS_INIT;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

[design/ssh_fold.sv]
// One-byte fold step of the selectable string hash.
// Depends on ssh_pkg.
module ssh_fold (
    input  ssh_pkg::fold_ctl_t ctl,
    input  logic [31:0]        hash_cur,
    input  logic [31:0]        mult_cur,
    input  logic [7:0]         data_byte,
    output logic [31:0]        hash_next
);

    logic [31:0] c;

    assign c = {24'd0, data_byte};

    always_comb
    begin
        unique case (ctl.algo)
            ssh_pkg::ALG_DJB:  hash_next = hash_cur + (hash_cur << 5) + c;
            ssh_pkg::ALG_BKDR: hash_next = hash_cur * ssh_pkg::BKDR_SEED + c;
            ssh_pkg::ALG_RS:   hash_next = hash_cur * mult_cur + c;
            ssh_pkg::ALG_AP:
            begin
                if (ctl.odd)
                    hash_next = hash_cur ^ ~((hash_cur << 11) ^ c ^ (hash_cur >> 5));
                else
                    hash_next = hash_cur ^ ((hash_cur << 7) ^ c ^ (hash_cur >> 3));
            end
            default:           hash_next = hash_cur ^ ((hash_cur << 5) + c + (hash_cur >> 2));
        endcase
    end

endmodule

[design/selectable_string_hash.sv]
// selectable_string_hash: string hash with a selectable algorithm.
// Depends on ssh_pkg and ssh_fold.
//
// Input channel: data_byte and is_last with in_valid / in_stall; one byte per
// item, is_last marks the final byte of a string. Output channel: hash_value
// with out_valid / out_stall; one item per string, given for its last byte.
// hash_select, written through hash_select_we, picks the algorithm: 0 DJB,
// 1 BKDR, 2 RS, 3 AP, 4 JS; 5..7 act as 0..2. The user must write it only
// while idle; the block itself does not enforce this. A byte enters the
// input register, is folded from there and the hash of a last byte lands in
// the output register. Throughput: one byte per cycle while in_stall is low;
// the fold of one byte (one 32x32 multiply plus add for RS) sets the cycle.
// When out_stall holds a result, non-last bytes keep flowing; a following last
// byte waits in the input register and in_stall rises until the result is taken.
// Reset clears the valid flags of both registers, selects DJB and marks the
// start of a string.
module selectable_string_hash (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        hash_select_we,
    input  logic [2:0]  hash_select,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        is_last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] hash_value
);

    logic [2:0]          sel_reg;
    logic                s1_valid_reg;
    logic [7:0]          s1_byte_reg;
    logic                s1_last_reg;
    logic [31:0]         hash_reg;
    logic [31:0]         mult_reg;
    logic                odd_reg;
    logic                start_reg;
    logic                out_valid_reg;
    logic [31:0]         out_hash_reg;

    logic                out_free;
    logic                s1_fire;
    logic                accept;
    ssh_pkg::algo_t      algo;
    ssh_pkg::fold_ctl_t  ctl;
    logic [31:0]         hash_cur;
    logic [31:0]         mult_cur;
    logic [31:0]         hash_next;

    assign out_free = !out_valid_reg || !out_stall;
    assign s1_fire  = s1_valid_reg && (!s1_last_reg || out_free);
    assign in_stall = s1_valid_reg && !s1_fire;
    assign accept   = in_valid && !in_stall;

    assign algo     = ssh_pkg::algo_of(sel_reg);
    assign hash_cur = start_reg ? ssh_pkg::init_of(algo) : hash_reg;
    assign mult_cur = start_reg ? ssh_pkg::RS_M_INIT : mult_reg;
    assign ctl.algo = algo;
    assign ctl.odd  = start_reg ? 1'b0 : odd_reg;

    ssh_fold u_fold (
        .ctl       (ctl),
        .hash_cur  (hash_cur),
        .mult_cur  (mult_cur),
        .data_byte (s1_byte_reg),
        .hash_next (hash_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg       <= 3'd0;
            s1_valid_reg  <= 1'b0;
            hash_reg      <= ssh_pkg::DJB_INIT;
            mult_reg      <= ssh_pkg::RS_M_INIT;
            odd_reg       <= 1'b0;
            start_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (hash_select_we)
                sel_reg <= hash_select;
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (s1_fire)
                s1_valid_reg <= 1'b0;
            if (s1_fire)
            begin
                hash_reg  <= hash_next;
                mult_reg  <= mult_cur * ssh_pkg::RS_M_STEP;
                odd_reg   <= !ctl.odd;
                start_reg <= s1_last_reg;
            end
            if (s1_fire && s1_last_reg)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_byte_reg <= data_byte;
            s1_last_reg <= is_last;
        end
        if (s1_fire && s1_last_reg)
            out_hash_reg <= hash_next;
    end

    assign out_valid  = out_valid_reg;
    assign hash_value = out_hash_reg;

endmodule

[design/ssh_checker.sv]
// Port-level checker for selectable_string_hash, bound to the top level.
// Depends on selectable_string_hash_assert.svh.
`include "selectable_string_hash_assert.svh"

module ssh_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        is_last,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] hash_value
);

    // held result stays put
    `SSH_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(hash_value))
    // input backs up only behind a stalled result
    `SSH_ASSERT_SAME(a_in_stall_cause, in_stall, out_valid && out_stall)
    // a fresh result traces back to a last byte taken at the input
    `SSH_ASSERT_SAME(a_out_source, $rose(out_valid),
                     $past(in_valid && !in_stall && is_last, 2))

endmodule

bind selectable_string_hash ssh_checker u_ssh_checker (.*);

[tb/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for selectable_string_hash: drives byte items through
// every hash selector, predicts each string hash and checks the output items.
// Depends on ssh_pkg and the selectable_string_hash RTL.
module testbench;

    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned RANDOM_ITEMS = 1200;
    localparam int unsigned MAX_REPORTS = 30;

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
    } byte_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        hash_select_we = 1'b0;
    logic [2:0]  hash_select = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = '0;
    logic        is_last = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] hash_value;

    byte_item_t  send_q[$];
    logic [31:0] hash_due[$];
    byte_item_t  nxt;
    int unsigned send_gap = 0;
    int unsigned stall_left = 0;
    int unsigned mismatches = 0;
    int unsigned cycles = 0;
    bit          calm = 1'b0;

    // predictor state
    logic [2:0]  sel_now = '0;
    logic [31:0] run_hash = ssh_pkg::DJB_INIT;
    logic [31:0] rs_mult = ssh_pkg::RS_M_INIT;
    logic        odd_pos = 1'b0;
    logic        at_start = 1'b1;

    selectable_string_hash dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .hash_select_we (hash_select_we),
        .hash_select    (hash_select),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .is_last        (is_last),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .hash_value     (hash_value)
    );

    always #4 clk = ~clk;

    function automatic ssh_pkg::algo_t pick_algo(input logic [2:0] sel);
        return ssh_pkg::algo_t'(sel % 3'd5);
    endfunction

    function automatic logic [31:0] start_hash(input ssh_pkg::algo_t a);
        if (a == ssh_pkg::ALG_DJB)
            return ssh_pkg::DJB_INIT;
        else if (a == ssh_pkg::ALG_JS)
            return ssh_pkg::JS_INIT;
        return 32'd0;
    endfunction

    function automatic void fold_byte(input logic [7:0] c, input logic fin);
        ssh_pkg::algo_t a;
        logic [31:0]    h;
        logic [31:0]    cx;
        a = pick_algo(sel_now);
        cx = {24'd0, c};
        if (at_start)
        begin
            run_hash = start_hash(a);
            rs_mult = ssh_pkg::RS_M_INIT;
            odd_pos = 1'b0;
            at_start = 1'b0;
        end
        h = run_hash;
        case (a)
            ssh_pkg::ALG_DJB:  h = h + (h << 5) + cx;
            ssh_pkg::ALG_BKDR: h = h * ssh_pkg::BKDR_SEED + cx;
            ssh_pkg::ALG_RS:   h = h * rs_mult + cx;
            ssh_pkg::ALG_AP:
            begin
                if (odd_pos)
                    h = h ^ ~((h << 11) ^ cx ^ (h >> 5));
                else
                    h = h ^ ((h << 7) ^ cx ^ (h >> 3));
            end
            default:           h = h ^ ((h << 5) + cx + (h >> 2));
        endcase
        run_hash = h;
        rs_mult = rs_mult * ssh_pkg::RS_M_STEP;
        odd_pos = ~odd_pos;
        if (fin)
        begin
            hash_due.push_back(h);
            at_start = 1'b1;
        end
    endfunction

    function automatic int unsigned pause_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic report(input string msg);
        if (mismatches < MAX_REPORTS)
            $display("mismatch @%0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic queue_item(input logic [7:0] ch, input logic fin);
        byte_item_t it;
        it.ch = ch;
        it.fin = fin;
        send_q.push_back(it);
    endtask

    task automatic queue_string(input int unsigned len, input bit close);
        for (int unsigned i = 0; i < len; i++)
            queue_item(8'($urandom_range(0, 255)), close && (i == len - 1));
    endtask

    task automatic settle();
        while (send_q.size() != 0 || in_valid || hash_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_select(input logic [2:0] v);
        @(posedge clk);
        hash_select_we <= 1'b1;
        hash_select <= v;
        sel_now = v;
        @(posedge clk);
        hash_select_we <= 1'b0;
    endtask

    // input driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            data_byte <= '0;
            is_last <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                fold_byte(data_byte, is_last);
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (send_q.size() > 0)
                begin
                    nxt = send_q.pop_front();
                    in_valid <= 1'b1;
                    data_byte <= nxt.ch;
                    is_last <= nxt.fin;
                    send_gap = calm ? 0 : pause_len();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // output monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (hash_due.size() == 0)
                    report($sformatf("unexpected hash %08h", hash_value));
                else if (hash_value !== hash_due[0])
                    report($sformatf("hash %08h, want %08h", hash_value, hash_due.pop_front()));
                else
                    void'(hash_due.pop_front());
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                if (!calm && $urandom_range(0, 3) == 0)
                    stall_left = pause_len();
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        int unsigned queued;
        int unsigned budget;
        int unsigned n;
        int unsigned len;
        bit          close;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset selector, single-byte strings at both byte extremes
        queue_item(8'hFF, 1'b1);
        queue_item(8'h00, 1'b1);
        settle();
        // every selector, including the wrapped ones; two bytes hit both AP positions
        for (int s = 0; s < 8; s++)
        begin
            write_select(3'(s));
            queue_item(8'hFF, 1'b0);
            queue_item(8'h00, 1'b1);
            settle();
        end
        // selector change in the middle of a string
        write_select(ssh_pkg::ALG_AP);
        queue_item(8'h55, 1'b0);
        queue_item(8'hAA, 1'b0);
        settle();
        write_select(ssh_pkg::ALG_JS);
        queue_item(8'h01, 1'b1);
        settle();

        queued = 0;
        while (queued < RANDOM_ITEMS)
        begin
            write_select(3'($urandom_range(0, 7)));
            calm = ($urandom_range(0, 4) == 0);
            budget = $urandom_range(40, 160);
            n = 0;
            while (n < budget)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 64)
                                                  : $urandom_range(1, 10);
                close = (n + len < budget) || ($urandom_range(0, 3) != 0);
                queue_string(len, close);
                n += len;
            end
            queued += n;
            settle();
        end

        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
